### rtl/core/asrp_pkg.sv
// ----------------------------------------------------------------------------
// asrp_pkg
// Shared types and codes for the ARM static relocation patcher.
// ----------------------------------------------------------------------------
package asrp_pkg;

   // relocation type codes (info word bits 7:0)
   localparam logic [7:0] RELOC_ABS32 = 8'd2;
   localparam logic [7:0] RELOC_V4BX  = 8'd40;
   localparam logic [7:0] RELOC_MOVW  = 8'd43;
   localparam logic [7:0] RELOC_MOVT  = 8'd44;
   localparam logic [7:0] RELOC_TMOVW = 8'd47;
   localparam logic [7:0] RELOC_TMOVT = 8'd48;

   // result status codes
   localparam logic [2:0] STATUS_OK           = 3'd0;
   localparam logic [2:0] STATUS_BAD_INDEX    = 3'd1;
   localparam logic [2:0] STATUS_UNRESOLVED   = 3'd2;
   localparam logic [2:0] STATUS_NOT_WRITABLE = 3'd3;
   localparam logic [2:0] STATUS_UNSUPPORTED  = 3'd4;

   // register indexes on the csr port
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEXT_LINK_BASE  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEXT_SPAN       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEXT_OFFSET_ADD = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DATA_LINK_BASE  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DATA_SPAN       = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_DATA_OFFSET_ADD = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_COPY_FLAGS      = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYMBOL_COUNT    = 3'd7;

   localparam int unsigned REQ_DATA_W = 144;
   localparam int unsigned RSP_DATA_W = 72;

   typedef struct packed {
      logic [31:0] text_link_base;
      logic [31:0] text_span;
      logic [31:0] text_offset_add;
      logic [31:0] data_link_base;
      logic [31:0] data_span;
      logic [31:0] data_offset_add;
      logic [1:0]  copy_flags;
      logic [15:0] symbol_count;
   } cfg_type;

   typedef struct packed {
      logic [31:0] rel_info;
      logic [31:0] rel_target;
      logic [31:0] symbol_value;
      logic [15:0] symbol_section;
      logic [31:0] target_word;
   } req_item_type;

   // handoff from the resolve stage to the patch stage
   typedef struct packed {
      logic [2:0]  status;      // outcome of the checks ahead of the type check
      logic        check_type;  // all checks passed, type still to be decoded
      logic [7:0]  rel_type;
      logic [31:0] run_symbol;
      logic [31:0] addend;      // target_word - symbol_value
      logic [31:0] target_word;
      logic        in_data;
      logic [31:0] offset;
   } resolve_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        write_enable;
      logic        target_in_data;
      logic [31:0] target_offset;
      logic [31:0] patched_word;
   } rsp_item_type;

endpackage

### rtl/core/arm_static_reloc_patcher.sv
// ----------------------------------------------------------------------------
// arm_static_reloc_patcher
// Applies one ARM ELF static relocation entry per item.
// ----------------------------------------------------------------------------
// Each req item is one relocation entry together with its symbol's value and
// section and the current word at the target; each rsp item gives a status,
// whether to write back, which copy (text or data) the target lies in, the
// byte offset there and the new word. One result per entry, in order. The
// block takes one entry per clock, held off only by rsp back-pressure, through
// an input register, a resolve stage (range checks, run symbol address,
// target offset) and a patch stage that holds the result register. All three
// stages advance independently, so a stalled rsp side fills the pipe before
// req_tready drops. Configuration is taken on the csr port at any time it is
// valid (csr_ready is tied high); write it only while no entry is in flight.
// ----------------------------------------------------------------------------
module arm_static_reloc_patcher (
   input  logic                                 clock,
   input  logic                                 reset,

   // req_tdata, low bit up: rel_info[31:0], rel_target[31:0],
   // symbol_value[31:0], symbol_section[15:0], target_word[31:0]
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [asrp_pkg::REQ_DATA_W-1:0]      req_tdata,

   // rsp_tdata, low bit up: status[2:0], write_enable, target_in_data,
   // target_offset[31:0], patched_word[31:0], 3 zero pad bits
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [asrp_pkg::RSP_DATA_W-1:0]      rsp_tdata,

   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [asrp_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [31:0]                          csr_data
);
   import asrp_pkg::*;

   cfg_type      cfg;
   req_item_type item_ff, item_in;
   resolve_type  res;
   rsp_item_type rsp;

   logic in_valid_ff, in_valid_in;
   logic mid_valid_ff, mid_valid_in;
   logic out_valid_ff, out_valid_in;
   logic out_free, mid_free, in_free;
   logic req_take;

   assign csr_ready = 1'b1;

   asrp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Each stage may load when it is empty or its content moves on.
   assign out_free   = !out_valid_ff || rsp_tready;
   assign mid_free   = !mid_valid_ff || out_free;
   assign in_free    = !in_valid_ff || mid_free;
   assign req_tready = in_free;
   assign req_take   = req_tvalid && in_free;

   assign in_valid_in  = in_free  ? req_tvalid   : in_valid_ff;
   assign mid_valid_in = mid_free ? in_valid_ff  : mid_valid_ff;
   assign out_valid_in = out_free ? mid_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         mid_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         mid_valid_ff <= mid_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // input register, unpacked from the stream word
   always_comb begin
      item_in.rel_info       = req_tdata[31:0];
      item_in.rel_target     = req_tdata[63:32];
      item_in.symbol_value   = req_tdata[95:64];
      item_in.symbol_section = req_tdata[111:96];
      item_in.target_word    = req_tdata[143:112];
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= item_in;
      end
   end

   asrp_resolve u_resolve (
      .clock (clock),
      .load  (in_valid_ff && mid_free),
      .cfg   (cfg),
      .item  (item_ff),
      .res   (res)
   );

   asrp_patch u_patch (
      .clock (clock),
      .load  (mid_valid_ff && out_free),
      .res   (res),
      .rsp   (rsp)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, rsp.patched_word, rsp.target_offset,
                        rsp.target_in_data, rsp.write_enable, rsp.status};

   // a write-back only comes with a clean status
   a_write_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp.write_enable) |-> (rsp.status == STATUS_OK))
      else $error("write enabled with failing status");

   // without write-back, copy select and offset read as zero
   a_nowrite_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp.write_enable) |->
      (!rsp.target_in_data && (rsp.target_offset == 32'd0)))
      else $error("stale target fields on a no-write result");

   // status stays within the defined codes
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp.status <= STATUS_UNSUPPORTED))
      else $error("undefined status code");

   // an accepted item is held in the input stage next cycle
   a_take_lands: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> in_valid_ff)
      else $error("accepted item lost at input register");

   // a full, stalled pipe takes nothing
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && mid_valid_ff && out_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("item accepted into a full pipeline");

endmodule

### rtl/core/asrp_csr.sv
// ----------------------------------------------------------------------------
// asrp_csr
// Configuration register file, one write per cycle, always ready.
// ----------------------------------------------------------------------------
module asrp_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   input  logic [asrp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]                      csr_data,
   output asrp_pkg::cfg_type                cfg
);
   import asrp_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_TEXT_LINK_BASE:  cfg_in.text_link_base  = csr_data;
            CSR_TEXT_SPAN:       cfg_in.text_span       = csr_data;
            CSR_TEXT_OFFSET_ADD: cfg_in.text_offset_add = csr_data;
            CSR_DATA_LINK_BASE:  cfg_in.data_link_base  = csr_data;
            CSR_DATA_SPAN:       cfg_in.data_span       = csr_data;
            CSR_DATA_OFFSET_ADD: cfg_in.data_offset_add = csr_data;
            CSR_COPY_FLAGS:      cfg_in.copy_flags      = csr_data[1:0];
            CSR_SYMBOL_COUNT:    cfg_in.symbol_count    = csr_data[15:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/core/asrp_resolve.sv
// ----------------------------------------------------------------------------
// asrp_resolve
// Second stage: index, symbol and target checks, run address of the symbol.
// ----------------------------------------------------------------------------
module asrp_resolve (
   input  logic                   clock,
   input  logic                   load,
   input  asrp_pkg::cfg_type      cfg,
   input  asrp_pkg::req_item_type item,
   output asrp_pkg::resolve_type  res
);
   import asrp_pkg::*;

   resolve_type res_ff, res_in;

   logic [7:0]  rel_type;
   logic [23:0] sym_index;
   logic [31:0] sym_text_rel, sym_data_rel, tgt_text_rel, tgt_data_rel;
   logic        sym_text, sym_data, tgt_text, tgt_data;
   logic [31:0] run_symbol;
   logic        resolved;

   // a - base is compared against span only when a >= base
   assign sym_text_rel = item.symbol_value - cfg.text_link_base;
   assign sym_data_rel = item.symbol_value - cfg.data_link_base;
   assign tgt_text_rel = item.rel_target - cfg.text_link_base;
   assign tgt_data_rel = item.rel_target - cfg.data_link_base;

   always_comb begin
      rel_type  = item.rel_info[7:0];
      sym_index = item.rel_info[31:8];

      sym_text = (item.symbol_section != 16'd0) &&
                 (item.symbol_value >= cfg.text_link_base) &&
                 (sym_text_rel < cfg.text_span);
      sym_data = (item.symbol_section != 16'd0) &&
                 (item.symbol_value >= cfg.data_link_base) &&
                 (sym_data_rel < cfg.data_span);
      run_symbol = sym_text ? item.symbol_value + cfg.text_offset_add
                            : item.symbol_value + cfg.data_offset_add;
      resolved = (sym_text || sym_data) && !run_symbol[31];

      tgt_text = cfg.copy_flags[0] && (item.rel_target >= cfg.text_link_base) &&
                 (tgt_text_rel < cfg.text_span);
      tgt_data = cfg.copy_flags[1] && (item.rel_target >= cfg.data_link_base) &&
                 (tgt_data_rel < cfg.data_span);

      res_in.check_type = 1'b0;
      if (rel_type == RELOC_V4BX) begin
         res_in.status = STATUS_OK;
      end else if (sym_index >= {8'd0, cfg.symbol_count}) begin
         res_in.status = STATUS_BAD_INDEX;
      end else if (!resolved) begin
         res_in.status = STATUS_UNRESOLVED;
      end else if (!(tgt_text || tgt_data)) begin
         res_in.status = STATUS_NOT_WRITABLE;
      end else begin
         res_in.status     = STATUS_OK;
         res_in.check_type = 1'b1;
      end
      res_in.rel_type    = rel_type;
      res_in.run_symbol  = run_symbol;
      res_in.addend      = item.target_word - item.symbol_value;
      res_in.target_word = item.target_word;
      res_in.in_data     = !tgt_text;
      res_in.offset      = tgt_text ? tgt_text_rel : tgt_data_rel;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule

### rtl/core/asrp_patch.sv
// ----------------------------------------------------------------------------
// asrp_patch
// Third stage: type decode, word rebase or imm16 insert, result register.
// ----------------------------------------------------------------------------
module asrp_patch (
   input  logic                   clock,
   input  logic                   load,
   input  asrp_pkg::resolve_type  res,
   output asrp_pkg::rsp_item_type rsp
);
   import asrp_pkg::*;

   rsp_item_type rsp_ff, rsp_in;

   logic [31:0] new_word;
   logic        supported;

   // ARM MOVW/MOVT: imm4 in bits 19:16, imm12 in bits 11:0
   function automatic logic [31:0] a32_imm16(input logic [31:0] w,
                                             input logic [15:0] imm);
      logic [31:0] r;
      r        = w;
      r[19:16] = imm[15:12];
      r[11:0]  = imm[11:0];
      return r;
   endfunction

   // Thumb-2 MOVW/MOVT: first halfword in 15:0, second in 31:16
   function automatic logic [31:0] t32_imm16(input logic [31:0] w,
                                             input logic [15:0] imm);
      logic [31:0] r;
      r        = w;
      r[3:0]   = imm[15:12];  // imm4
      r[10]    = imm[11];     // i
      r[30:28] = imm[10:8];   // imm3
      r[23:16] = imm[7:0];    // imm8
      return r;
   endfunction

   always_comb begin
      supported = 1'b1;
      case (res.rel_type)
         RELOC_ABS32: new_word = res.run_symbol + res.addend;
         RELOC_MOVW:  new_word = a32_imm16(res.target_word, res.run_symbol[15:0]);
         RELOC_MOVT:  new_word = a32_imm16(res.target_word, res.run_symbol[31:16]);
         RELOC_TMOVW: new_word = t32_imm16(res.target_word, res.run_symbol[15:0]);
         RELOC_TMOVT: new_word = t32_imm16(res.target_word, res.run_symbol[31:16]);
         default: begin
            new_word  = res.target_word;
            supported = 1'b0;
         end
      endcase

      rsp_in.status         = res.status;
      rsp_in.write_enable   = 1'b0;
      rsp_in.target_in_data = 1'b0;
      rsp_in.target_offset  = '0;
      rsp_in.patched_word   = res.target_word;
      if (res.check_type) begin
         if (supported) begin
            rsp_in.write_enable   = 1'b1;
            rsp_in.target_in_data = res.in_data;
            rsp_in.target_offset  = res.offset;
            rsp_in.patched_word   = new_word;
         end else begin
            rsp_in.status = STATUS_UNSUPPORTED;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

endmodule

### sim/tb_arm_static_reloc_patcher.sv
// ----------------------------------------------------------------------------
// tb_arm_static_reloc_patcher
// Self-checking bench for the ARM static relocation patcher.
// ----------------------------------------------------------------------------
// A directed table covers the reset state, each check in its order of
// priority, the span edges and every relocation type. After it come random
// register settings, each with a burst of mostly well-formed relocation
// entries. Every rsp item is compared field by field with the result
// predicted when its entry was accepted.
// ----------------------------------------------------------------------------
module tb_arm_static_reloc_patcher;
   timeunit 1ns;
   timeprecision 1ps;

   import asrp_pkg::*;

   localparam int unsigned RANDOM_PHASES  = 14;
   localparam int unsigned PHASE_ENTRIES  = 102;
   localparam int unsigned PRESSURE_PHASE = 5;
   localparam int unsigned MISMATCH_SHOWN = 40;

   // raw register values as written on the csr port (upper bits not masked)
   typedef struct {
      logic [31:0] text_link_base;
      logic [31:0] text_span;
      logic [31:0] text_offset_add;
      logic [31:0] data_link_base;
      logic [31:0] data_span;
      logic [31:0] data_offset_add;
      logic [31:0] copy_flags;
      logic [31:0] symbol_count;
   } reg_image_type;

   // one line of the directed table
   typedef struct {
      logic         use_reset_regs;  // run with the settings left by reset
      req_item_type entry;
      logic         has_golden;      // expected result typed in below
      rsp_item_type golden;
   } table_row_type;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic [REQ_DATA_W-1:0]   req_tdata  = '0;
   logic                    rsp_tready = 1'b0;
   logic                    csr_valid  = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index  = CSR_TEXT_LINK_BASE;
   logic [31:0]             csr_data   = '0;
   logic                    req_tready;
   logic                    rsp_tvalid;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    csr_ready;

   cfg_type        live_cfg = '0;       // our copy of the block's registers
   rsp_item_type   pending_patches[$];  // predicted results, oldest first
   table_row_type  dir_rows[$];
   bit             idle_on = 1'b1;      // allow random gaps and stalls
   int             rsp_stall_left = 0;
   int             mismatch_count = 0;
   int             results_checked = 0;
   int             written_back = 0;
   int             settings_loaded = 0;
   int             status_tally[8];

   arm_static_reloc_patcher i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // hard stop well past the slowest legal run
   initial begin
      #(5_000_000);
      $display("arm_static_reloc_patcher: mismatch");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // address lies in [base, base + span), with no wrap past 2^32
   function automatic logic span_hit(logic [31:0] addr, logic [31:0] base,
                                     logic [31:0] span);
      logic [31:0] rel_off;
      rel_off = addr - base;
      return (addr >= base) && (rel_off < span);
   endfunction

   // A32 MOVW/MOVT: imm4 in bits 19:16, imm12 in bits 11:0
   function automatic logic [31:0] arm_imm16(logic [31:0] word, logic [15:0] imm);
      logic [31:0] w;
      w        = word;
      w[19:16] = imm[15:12];
      w[11:0]  = imm[11:0];
      return w;
   endfunction

   // T32 MOVW/MOVT: first halfword low (imm4, i), second halfword high
   // (imm3, imm8)
   function automatic logic [31:0] thumb_imm16(logic [31:0] word, logic [15:0] imm);
      logic [31:0] w;
      w        = word;
      w[3:0]   = imm[15:12];
      w[10]    = imm[11];
      w[30:28] = imm[10:8];
      w[23:16] = imm[7:0];
      return w;
   endfunction

   function automatic rsp_item_type predict_patch(cfg_type c, req_item_type e);
      rsp_item_type r;
      logic [7:0]   kind;
      logic [23:0]  sym_idx;
      logic [31:0]  run_sym;
      logic [31:0]  dest_off;
      logic [31:0]  new_word;
      logic         resolved;
      logic         writable;
      logic         dest_data;
      logic         known;
      r              = '0;
      r.status       = STATUS_OK;
      r.patched_word = e.target_word;
      kind           = e.rel_info[7:0];
      sym_idx        = e.rel_info[31:8];
      run_sym        = '0;
      dest_off       = '0;
      new_word       = e.target_word;
      resolved       = 1'b0;
      writable       = 1'b0;
      dest_data      = 1'b0;
      known          = 1'b1;

      // marker only, nothing to patch
      if (kind == RELOC_V4BX)
         return r;

      if ({8'd0, sym_idx} >= {16'd0, c.symbol_count}) begin
         r.status = STATUS_BAD_INDEX;
         return r;
      end

      // section 0 = undefined; text is tried before data
      if (e.symbol_section != 16'd0) begin
         if (span_hit(e.symbol_value, c.text_link_base, c.text_span)) begin
            run_sym  = e.symbol_value + c.text_offset_add;
            resolved = 1'b1;
         end else if (c.data_span != 32'd0 &&
                      span_hit(e.symbol_value, c.data_link_base, c.data_span)) begin
            run_sym  = e.symbol_value + c.data_offset_add;
            resolved = 1'b1;
         end
      end
      // a run address with the top bit set counts as unresolved
      if (!resolved || run_sym[31]) begin
         r.status = STATUS_UNRESOLVED;
         return r;
      end

      if (c.copy_flags[0] && span_hit(e.rel_target, c.text_link_base, c.text_span)) begin
         dest_data = 1'b0;
         dest_off  = e.rel_target - c.text_link_base;
         writable  = 1'b1;
      end else if (c.copy_flags[1] && c.data_span != 32'd0 &&
                   span_hit(e.rel_target, c.data_link_base, c.data_span)) begin
         dest_data = 1'b1;
         dest_off  = e.rel_target - c.data_link_base;
         writable  = 1'b1;
      end
      if (!writable) begin
         r.status = STATUS_NOT_WRITABLE;
         return r;
      end

      case (kind)
         RELOC_ABS32: new_word = run_sym + (e.target_word - e.symbol_value);
         RELOC_MOVW:  new_word = arm_imm16(e.target_word, run_sym[15:0]);
         RELOC_MOVT:  new_word = arm_imm16(e.target_word, run_sym[31:16]);
         RELOC_TMOVW: new_word = thumb_imm16(e.target_word, run_sym[15:0]);
         RELOC_TMOVT: new_word = thumb_imm16(e.target_word, run_sym[31:16]);
         default:     known = 1'b0;
      endcase
      if (!known) begin
         r.status = STATUS_UNSUPPORTED;
         return r;
      end

      r.write_enable   = 1'b1;
      r.target_in_data = dest_data;
      r.target_offset  = dest_off;
      r.patched_word   = new_word;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // directed rows; golden rows are always no-write results
   function automatic void add_row(logic reset_regs, logic [31:0] info,
                                   logic [31:0] tgt, logic [31:0] sval,
                                   logic [15:0] sec, logic [31:0] word,
                                   logic golden_on, logic [2:0] golden_status);
      table_row_type row;
      row.use_reset_regs       = reset_regs;
      row.entry.rel_info       = info;
      row.entry.rel_target     = tgt;
      row.entry.symbol_value   = sval;
      row.entry.symbol_section = sec;
      row.entry.target_word    = word;
      row.has_golden           = golden_on;
      row.golden               = '0;
      row.golden.status        = golden_status;
      row.golden.patched_word  = word;
      dir_rows.push_back(row);
   endfunction

   // address inside a segment, or anywhere if it is empty
   function automatic logic [31:0] addr_in(logic [31:0] base, logic [31:0] span);
      if (span == 32'd0)
         return $urandom;
      return base + ($urandom % span);
   endfunction

   function automatic reg_image_type make_settings(int unsigned phase);
      reg_image_type img;
      if (phase == 0) begin
         img = '{default: 32'h0000_0000};
      end else if (phase == 1) begin
         img = '{default: 32'hFFFF_FFFF};
      end else begin
         img.text_link_base = ($urandom_range(0, 3) == 0) ? $urandom
                                                          : ($urandom & 32'h0FFF_FFF0);
         case ($urandom_range(0, 7))
            0:       img.text_span = 32'd0;
            1:       img.text_span = $urandom;
            2, 3:    img.text_span = $urandom_range(1, 64);
            default: img.text_span = $urandom_range(65, 32'h0004_0000);
         endcase
         img.text_offset_add = ($urandom_range(0, 3) == 0) ? $urandom
                                                           : $urandom_range(0, 32'h3FFF_FFFF);
         // data usually sits just above text, sometimes anywhere (overlap too)
         img.data_link_base = ($urandom_range(0, 5) == 0)
                            ? $urandom
                            : img.text_link_base + img.text_span + $urandom_range(0, 256);
         case ($urandom_range(0, 4))
            0:       img.data_span = 32'd0;
            1:       img.data_span = $urandom_range(1, 64);
            default: img.data_span = $urandom_range(65, 32'h0002_0000);
         endcase
         img.data_offset_add = ($urandom_range(0, 3) == 0) ? $urandom
                                                           : $urandom_range(0, 32'h3FFF_FFFF);
         img.copy_flags   = $urandom;
         img.symbol_count = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 4096);
      end
      return img;
   endfunction

   // mostly well-formed entries aimed at the segments, some noise
   function automatic req_item_type random_entry(cfg_type c);
      req_item_type e;
      logic [7:0]   kind;
      logic [23:0]  sym_idx;
      int unsigned  pick;
      pick = $urandom_range(0, 19);
      if (pick < 5)       kind = RELOC_ABS32;
      else if (pick < 8)  kind = RELOC_MOVW;
      else if (pick < 10) kind = RELOC_MOVT;
      else if (pick < 12) kind = RELOC_TMOVW;
      else if (pick < 14) kind = RELOC_TMOVT;
      else if (pick < 15) kind = RELOC_V4BX;
      else if (pick < 17) kind = 8'($urandom);
      else                kind = RELOC_ABS32;

      pick = $urandom_range(0, 9);
      if (c.symbol_count != 16'd0 && pick < 7) sym_idx = 24'($urandom % c.symbol_count);
      else if (pick == 7)                      sym_idx = {8'd0, c.symbol_count};
      else                                     sym_idx = 24'($urandom);
      e.rel_info = {sym_idx, kind};

      pick = $urandom_range(0, 9);
      if (pick < 5)      e.symbol_value = addr_in(c.text_link_base, c.text_span);
      else if (pick < 8) e.symbol_value = addr_in(c.data_link_base, c.data_span);
      else               e.symbol_value = $urandom;

      e.symbol_section = ($urandom_range(0, 9) == 0) ? 16'd0
                                                     : 16'($urandom_range(1, 16'hFFFF));

      pick = $urandom_range(0, 9);
      if (pick < 5)      e.rel_target = addr_in(c.text_link_base, c.text_span);
      else if (pick < 8) e.rel_target = addr_in(c.data_link_base, c.data_span);
      else               e.rel_target = $urandom;

      e.target_word = $urandom;
      return e;
   endfunction

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_TEXT_LINK_BASE:  live_cfg.text_link_base  = value;
         CSR_TEXT_SPAN:       live_cfg.text_span       = value;
         CSR_TEXT_OFFSET_ADD: live_cfg.text_offset_add = value;
         CSR_DATA_LINK_BASE:  live_cfg.data_link_base  = value;
         CSR_DATA_SPAN:       live_cfg.data_span       = value;
         CSR_DATA_OFFSET_ADD: live_cfg.data_offset_add = value;
         CSR_COPY_FLAGS:      live_cfg.copy_flags      = value[1:0];
         CSR_SYMBOL_COUNT:    live_cfg.symbol_count    = value[15:0];
         default:             ;
      endcase
   endtask

   // only called with the pipe empty
   task automatic load_regs(reg_image_type img);
      write_reg(CSR_TEXT_LINK_BASE,  img.text_link_base);
      write_reg(CSR_TEXT_SPAN,       img.text_span);
      write_reg(CSR_TEXT_OFFSET_ADD, img.text_offset_add);
      write_reg(CSR_DATA_LINK_BASE,  img.data_link_base);
      write_reg(CSR_DATA_SPAN,       img.data_span);
      write_reg(CSR_DATA_OFFSET_ADD, img.data_offset_add);
      write_reg(CSR_COPY_FLAGS,      img.copy_flags);
      write_reg(CSR_SYMBOL_COUNT,    img.symbol_count);
      csr_valid <= 1'b0;
      settings_loaded++;
   endtask

   // hold off the sender until every predicted result is back, then let
   // the three-stage pipe settle
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_patches.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // valid stays high into the next item unless a gap is taken
   task automatic send_entry(req_item_type e, rsp_item_type want);
      int unsigned gap;
      if (idle_on && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 19);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {e.target_word, e.symbol_section, e.symbol_value,
                     e.rel_target, e.rel_info};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_patches.push_back(want);
   endtask

   task automatic note_mismatch(string field, logic [31:0] want_v, logic [31:0] got_v);
      mismatch_count++;
      if (mismatch_count <= MISMATCH_SHOWN)
         $display("%0t: %s expected %h actual %h", $time, field, want_v, got_v);
   endtask

   // ---------------------------------------------------------------------
   // Result checker and rsp-side stalls
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_item_type got;
      rsp_item_type want;
      if (rsp_tvalid && rsp_tready) begin
         got.status         = rsp_tdata[2:0];
         got.write_enable   = rsp_tdata[3];
         got.target_in_data = rsp_tdata[4];
         got.target_offset  = rsp_tdata[36:5];
         got.patched_word   = rsp_tdata[68:37];
         if (pending_patches.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MISMATCH_SHOWN)
               $display("%0t: rsp item expected none actual %h", $time, rsp_tdata);
         end else begin
            want = pending_patches.pop_front();
            results_checked++;
            status_tally[want.status]++;
            if (want.write_enable)
               written_back++;
            if (got.status !== want.status)
               note_mismatch("status", 32'(want.status), 32'(got.status));
            if (got.write_enable !== want.write_enable)
               note_mismatch("write_enable", 32'(want.write_enable),
                             32'(got.write_enable));
            if (got.target_in_data !== want.target_in_data)
               note_mismatch("target_in_data", 32'(want.target_in_data),
                             32'(got.target_in_data));
            if (got.target_offset !== want.target_offset)
               note_mismatch("target_offset", want.target_offset, got.target_offset);
            if (got.patched_word !== want.patched_word)
               note_mismatch("patched_word", want.patched_word, got.patched_word);
         end
      end

      // random stall bursts; none once idling is switched off, even one
      // that was still running
      if (rsp_stall_left > 0)
         rsp_stall_left--;
      else if (idle_on && $urandom_range(0, 15) == 0)
         rsp_stall_left = $urandom_range(1, 19);
      rsp_tready <= !idle_on || (rsp_stall_left == 0);
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      reg_image_type directed_img;
      req_item_type  e;
      rsp_item_type  want;
      bit            on_reset_regs;

      // directed settings: text 0x8000..0x17FFF, data 0x100000..0x100FFF;
      // the data offset pushes run addresses from 0x100400 up past bit 31
      directed_img = '{text_link_base:  32'h0000_8000,
                       text_span:       32'h0001_0000,
                       text_offset_add: 32'h2000_0000,
                       data_link_base:  32'h0010_0000,
                       data_span:       32'h0000_1000,
                       data_offset_add: 32'h7FEF_FC00,
                       copy_flags:      32'h0000_0003,
                       symbol_count:    32'h0000_0010};

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // after reset: no symbols, so only the marker gets through
      add_row(1, {24'hFF_FFFF, RELOC_V4BX}, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
              32'hFFFF_FFFF, 1, STATUS_OK);
      add_row(1, {24'd0, RELOC_ABS32}, 32'h0, 32'h0, 16'd1, 32'h1234_5678,
              1, STATUS_BAD_INDEX);
      add_row(1, {24'd0, 8'hFF}, 32'h0, 32'h0, 16'd1, 32'h0, 1, STATUS_BAD_INDEX);
      // index check: count itself and the top index fail, marker wins first
      add_row(0, {24'd16, RELOC_ABS32}, 32'h8000, 32'h8000, 16'd1, 32'h0,
              1, STATUS_BAD_INDEX);
      add_row(0, {24'hFF_FFFF, 8'hFF}, 32'h8000, 32'h8000, 16'd1, 32'h0,
              1, STATUS_BAD_INDEX);
      add_row(0, {24'hFF_FFFF, RELOC_V4BX}, 32'h8000, 32'h8000, 16'd1, 32'hA5A5_5A5A,
              1, STATUS_OK);
      // resolution: undefined section, just below / just past text,
      // data symbol whose run address has the top bit set
      add_row(0, {24'd15, RELOC_ABS32}, 32'h8010, 32'h9000, 16'd0, 32'h0,
              1, STATUS_UNRESOLVED);
      add_row(0, {24'd15, RELOC_ABS32}, 32'h8010, 32'h7FFF, 16'd1, 32'h0,
              1, STATUS_UNRESOLVED);
      add_row(0, {24'd15, RELOC_ABS32}, 32'h8010, 32'h1_8000, 16'd1, 32'h0,
              1, STATUS_UNRESOLVED);
      add_row(0, {24'd3, RELOC_ABS32}, 32'h8010, 32'h10_0400, 16'd1, 32'h0,
              1, STATUS_UNRESOLVED);
      // target just past text, just past data
      add_row(0, {24'd3, RELOC_ABS32}, 32'h1_8000, 32'h9000, 16'd1, 32'h0,
              1, STATUS_NOT_WRITABLE);
      add_row(0, {24'd3, RELOC_MOVW}, 32'h10_1000, 32'h9000, 16'd1, 32'h0,
              1, STATUS_NOT_WRITABLE);
      // type check comes last
      add_row(0, {24'd3, 8'd0}, 32'h8000, 32'h9000, 16'd1, 32'h0,
              1, STATUS_UNSUPPORTED);
      add_row(0, {24'd3, 8'hFF}, 32'h8000, 32'h9000, 16'd1, 32'hFFFF_FFFF,
              1, STATUS_UNSUPPORTED);
      // patched rows, left to the predictor
      add_row(0, {24'd0, RELOC_ABS32}, 32'h8000, 32'h8000, 16'hFFFF,
              32'hFFFF_FFFF, 0, STATUS_OK);
      add_row(0, {24'd1, RELOC_ABS32}, 32'h10_0FFF, 32'h1_7FFF, 16'd2, 32'h0, 0, STATUS_OK);
      add_row(0, {24'd2, RELOC_ABS32}, 32'h10_0000, 32'h10_0000, 16'd3,
              32'h0010_0040, 0, STATUS_OK);
      add_row(0, {24'd4, RELOC_MOVW}, 32'h9004, 32'h1_2345, 16'd1,
              32'hFFFF_FFFF, 0, STATUS_OK);
      add_row(0, {24'd5, RELOC_MOVT}, 32'h10_0010, 32'h1_0ABC, 16'd1, 32'h0, 0, STATUS_OK);
      add_row(0, {24'd6, RELOC_TMOVW}, 32'h1_7FFC, 32'h1_7FFF, 16'd1,
              32'hFFFF_FFFF, 0, STATUS_OK);
      add_row(0, {24'd7, RELOC_TMOVT}, 32'h8000, 32'h10_0123, 16'd1, 32'h0, 0, STATUS_OK);
      add_row(0, {24'd8, RELOC_TMOVW}, 32'h8ABC, 32'h8000, 16'd1, 32'h0, 0, STATUS_OK);
      add_row(0, {24'd9, RELOC_MOVW}, 32'h10_0800, 32'h10_0300, 16'd1, 32'h0, 0, STATUS_OK);

      on_reset_regs = 1'b1;
      foreach (dir_rows[i]) begin
         if (dir_rows[i].use_reset_regs != on_reset_regs) begin
            drain();
            load_regs(directed_img);
            on_reset_regs = 1'b0;
         end
         want = dir_rows[i].has_golden ? dir_rows[i].golden
                                       : predict_patch(live_cfg, dir_rows[i].entry);
         send_entry(dir_rows[i].entry, want);
      end

      // random part: all-zero and all-ones settings first, then mixed ones;
      // every fourth phase and the last run without gaps or stalls
      for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
         drain();
         idle_on = (p % 4 != 3) && (p != RANDOM_PHASES - 1);
         load_regs(make_settings(p));
         for (int unsigned n = 0; n < PHASE_ENTRIES; n++) begin
            if (p == PRESSURE_PHASE && n == PHASE_ENTRIES / 2)
               drain();
            e = random_entry(live_cfg);
            send_entry(e, predict_patch(live_cfg, e));
         end
      end

      drain();

      $display("covered %0d entries over %0d register settings, %0d written back",
               results_checked, settings_loaded, written_back);
      $display("status mix: ok %0d, bad index %0d, unresolved %0d, not writable %0d, unsupported %0d",
               status_tally[STATUS_OK], status_tally[STATUS_BAD_INDEX],
               status_tally[STATUS_UNRESOLVED], status_tally[STATUS_NOT_WRITABLE],
               status_tally[STATUS_UNSUPPORTED]);
      if (mismatch_count == 0)
         $display("arm_static_reloc_patcher: match");
      else
         $display("arm_static_reloc_patcher: mismatch");
      $finish;
   end

endmodule
